### src/abl_pkg.sv
package abl_pkg;

   // Default number of samples averaged per calibration.
   localparam int CAL_SAMPLES_DEF = 200;

   // Angles.
   localparam int ANG_W = 18;   // Q13 angle straight from the CORDIC
   localparam int SUM_W = 28;   // calibration sums
   localparam int OFF_W = 16;   // offsets and outputs

   // Multiply-accumulate datapath.
   localparam int MUL_W = 17;   // signed multiplier operands
   localparam int PRD_W = 34;   // signed product and accumulators
   localparam int SQ_W  = 57;   // square of the asin operand, Q56

   // Square root unit.
   localparam int RAD_W = 58;   // radicand, even width
   localparam int RT_W  = 29;   // root
   localparam int REM_W = 32;

   // CORDIC unit.
   localparam int CIN_W  = 35;  // operand width at the unit port
   localparam int CV_W   = 46;  // vector registers after the 256x prescale
   localparam int CZ_W   = 25;  // Q20 angle accumulator
   localparam int CIT_W  = 5;
   localparam int CORDIC_ITERS = 21;
   localparam logic signed [CZ_W-1:0] PI_Q20 = 25'sd3294199;
   localparam logic signed [ANG_W-1:0] HALF_PI_Q13 = 18'sd12868;

   // Divider unit.
   localparam int DN_W = 30;    // numerator and quotient
   localparam int DD_W = 13;    // divisor
   localparam int DR_W = 14;    // partial remainder

   typedef enum logic [1:0] {
      OP_SAMPLE = 2'd0,
      OP_CMD    = 2'd1,
      OP_RECAL  = 2'd2
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_ROOT,
      ST_ROLL,
      ST_PITCH,
      ST_AVG_GO,
      ST_AVG_R,
      ST_AVG_P
   } state_type;

   // Arctangent of 2^-i in Q20; beyond the table it equals 2^(20-i).
   function automatic logic [19:0] atan_q20(input logic [CIT_W-1:0] i);
      logic [19:0] v;
      case (i)
         5'd0: v = 20'd823550;
         5'd1: v = 20'd486170;
         5'd2: v = 20'd256879;
         5'd3: v = 20'd130396;
         5'd4: v = 20'd65451;
         5'd5: v = 20'd32757;
         5'd6: v = 20'd16383;
         5'd7: v = 20'd8192;
         5'd8: v = 20'd4096;
         default: v = 20'd1 << (5'd20 - i);
      endcase
      return v;
   endfunction

endpackage

### src/abl_isqrt.sv
module abl_isqrt
   import abl_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [RAD_W-1:0] radicand,
   output logic             done,
   output logic [RT_W-1:0]  root
);

   // Digit-by-digit root: two radicand bits enter per cycle.
   logic [RAD_W-1:0] rad_ff, rad_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [RT_W-1:0]  root_ff, root_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [REM_W-1:0] rem_sh, trial;

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1:RAD_W-2]};
      trial   = REM_W'({root_ff, 2'b01});
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[RAD_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[RT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[RT_W-2:0], 1'b0};
         end
         if (cnt_ff == 5'(RT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

### src/abl_cordic.sv
module abl_cordic
   import abl_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [CIN_W-1:0] y_val,
   input  logic signed [CIN_W-1:0] x_val,
   output logic                    done,
   output logic signed [ANG_W-1:0] angle
);

   // Vectoring CORDIC, one micro-rotation per cycle.
   logic signed [CV_W-1:0]  vx_ff, vx_in, vy_ff, vy_in;
   logic signed [CV_W-1:0]  xs, ys, x_pre, y_pre, x_shr, y_shr;
   logic signed [CZ_W-1:0]  z_ff, z_in, z_rnd, step_ang;
   logic [CIT_W-1:0]        it_ff, it_in;
   logic                    busy_ff, busy_in, done_ff, done_in;
   logic signed [ANG_W-1:0] res_ff, res_in;

   always_comb begin
      vx_in   = vx_ff;
      vy_in   = vy_ff;
      z_in    = z_ff;
      it_in   = it_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      res_in  = res_ff;
      z_rnd   = '0;
      x_pre   = {{(CV_W-CIN_W-8){x_val[CIN_W-1]}}, x_val, 8'b0};
      y_pre   = {{(CV_W-CIN_W-8){y_val[CIN_W-1]}}, y_val, 8'b0};
      x_shr   = vx_ff >>> it_ff;
      y_shr   = vy_ff >>> it_ff;
      step_ang = $signed(CZ_W'(atan_q20(it_ff)));
      xs = '0;
      ys = '0;
      if (start) begin
         if (x_val == '0 && y_val == '0) begin
            res_in  = '0;
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            if (x_val < 0) begin
               vx_in = -x_pre;
               vy_in = -y_pre;
               z_in  = (y_val >= 0) ? PI_Q20 : -PI_Q20;
            end else begin
               vx_in = x_pre;
               vy_in = y_pre;
               z_in  = '0;
            end
            it_in   = '0;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         xs = x_shr;
         ys = y_shr;
         if (vy_ff > 0) begin
            vx_in = vx_ff + ys;
            vy_in = vy_ff - xs;
            z_in  = z_ff + step_ang;
         end else begin
            vx_in = vx_ff - ys;
            vy_in = vy_ff + xs;
            z_in  = z_ff - step_ang;
         end
         if (it_ff == CIT_W'(CORDIC_ITERS - 1)) begin
            z_rnd   = z_in + 25'sd64;
            res_in  = ANG_W'(z_rnd >>> 7);
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            it_in = it_ff + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      vx_ff  <= vx_in;
      vy_ff  <= vy_in;
      z_ff   <= z_in;
      it_ff  <= it_in;
      res_ff <= res_in;
   end

   assign done  = done_ff;
   assign angle = res_ff;

endmodule

### src/abl_div.sv
module abl_div
   import abl_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [DN_W-1:0] numer,
   input  logic [DD_W-1:0] denom,
   output logic            done,
   output logic [DN_W-1:0] quot
);

   // Restoring division, one quotient bit per cycle.
   logic [DN_W-1:0] nq_ff, nq_in;
   logic [DR_W-1:0] rem_ff, rem_in, rem_sh;
   logic [DD_W-1:0] den_ff, den_in;
   logic [4:0]      cnt_ff, cnt_in;
   logic            busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      nq_in   = nq_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff[DR_W-2:0], nq_ff[DN_W-1]};
      if (start) begin
         nq_in   = numer;
         rem_in  = '0;
         den_in  = denom;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_sh >= DR_W'(den_ff)) begin
            rem_in = rem_sh - DR_W'(den_ff);
            nq_in  = {nq_ff[DN_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            nq_in  = {nq_ff[DN_W-2:0], 1'b0};
         end
         if (cnt_ff == 5'(DN_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      nq_ff  <= nq_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quot = nq_ff;

endmodule

### src/attitude_bias_leveler.sv
// Attitude bias leveler.
// The req_ stream carries one event per transfer: the kind sits in req_tuser
// (sample, command or recalibrate), quaternion parts and commanded angles in
// req_tdata. A recalibrate transfer clears the calibrated flag; from then on
// sample transfers are turned into roll and pitch angles and averaged into
// the offsets once CAL_SAMPLES are counted. While calibrated, each command
// transfer yields one rsp_ transfer with 1.5 times the commanded angles plus
// the offsets, saturated to 16 bits. All other events produce no response.
// A command or recalibrate does not leave the idle state, and a command's
// response is registered the cycle after acceptance. A sample keeps the block
// busy after its transfer: multiply-accumulate steps on one shared multiplier,
// the two-bit-per-cycle square root, and two passes through the iterative
// CORDIC; no new transfer is taken until it is done. When the asin operand
// saturates, the square root and the roll pass are skipped. The last sample
// of a calibration also runs two bit-serial divisions that form the averages.
// Reset is synchronous and leaves the block calibrated with zero offsets.
// While rsp_tready is low with a response pending, req_tready stays low; the
// held response is released as soon as the receiver takes it.
module attitude_bias_leveler
   import abl_pkg::*;
#(
   parameter int CAL_SAMPLES = CAL_SAMPLES_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // quat_w, quat_x, quat_y, quat_z, cmd_roll, cmd_pitch, 16 bits each
   input  logic [95:0] req_tdata,
   // opcode
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_roll, out_pitch, 16 bits each
   output logic [31:0] rsp_tdata
);

   state_type state_ff, state_in;
   logic [3:0] step_ff, step_in;
   logic       cal_ff, cal_in;
   logic [11:0] count_ff, count_in;
   logic [12:0] count_nx;
   logic signed [SUM_W-1:0] rsum_ff, rsum_in, psum_ff, psum_in, rbase, pbase;
   logic signed [OFF_W-1:0] roff_ff, roff_in, poff_ff, poff_in;
   logic signed [15:0] qw_ff, qw_in, qx_ff, qx_in, qy_ff, qy_in, qz_ff, qz_in;
   logic signed [PRD_W-1:0] acca_ff, acca_in, accb_ff, accb_in, accc_ff, accc_in;
   logic [PRD_W-1:0] amag;
   logic [SQ_W-1:0] sq_ff, sq_in, prod_ext;
   logic signed [ANG_W-1:0] rang_ff, rang_in, pang;
   logic rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;

   logic signed [MUL_W-1:0] mul_a, mul_b;
   logic signed [PRD_W-1:0] prod;
   logic a_sat;
   logic [13:0] s_hi, s_lo;

   logic req_xfer;
   opcode_type op;

   logic isq_start, isq_done;
   logic [RT_W-1:0] isq_root;
   logic cor_start, cor_done;
   logic signed [CIN_W-1:0] cor_y, cor_x;
   logic signed [ANG_W-1:0] cor_ang;
   logic div_start, div_done;
   logic [DN_W-1:0] div_numer, div_quot;
   logic [SUM_W-1:0] div_mag;
   logic signed [SUM_W-1:0] div_sum;
   logic signed [OFF_W-1:0] avg_q;

   // 1.5 * cmd + offset, with half steps rounded up, then saturated.
   function automatic logic [15:0] scale_sat(input logic signed [15:0] cmd,
                                             input logic signed [15:0] off);
      logic signed [18:0] c19, t, v;
      logic [15:0] r;
      c19 = {{3{cmd[15]}}, cmd};
      t   = c19 + (c19 <<< 1) + {{2{off[15]}}, off, 1'b0} + 19'sd1;
      v   = t >>> 1;
      if (v > 19'sd32767) begin
         r = 16'h7fff;
      end else if (v < -19'sd32768) begin
         r = 16'h8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   assign op         = opcode_type'(req_tuser);
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_xfer   = req_tvalid && req_tready;

   // Magnitude of A = xy + wz; the asin operand is 2A in Q28.
   assign amag  = acca_ff[PRD_W-1] ? PRD_W'(-acca_ff) : PRD_W'(acca_ff);
   assign a_sat = |amag[PRD_W-1:27];
   assign s_hi  = amag[26:13];
   assign s_lo  = {amag[12:0], 1'b0};

   // Operand selection for the shared multiplier.
   always_comb begin
      case (step_ff)
         4'd0:    begin mul_a = {qx_ff[15], qx_ff}; mul_b = {qy_ff[15], qy_ff}; end
         4'd1:    begin mul_a = {qw_ff[15], qw_ff}; mul_b = {qz_ff[15], qz_ff}; end
         4'd2:    begin mul_a = {qw_ff[15], qw_ff}; mul_b = {qy_ff[15], qy_ff}; end
         4'd3:    begin mul_a = {qx_ff[15], qx_ff}; mul_b = {qz_ff[15], qz_ff}; end
         4'd4:    begin mul_a = {qw_ff[15], qw_ff}; mul_b = {qw_ff[15], qw_ff}; end
         4'd5:    begin mul_a = {qx_ff[15], qx_ff}; mul_b = {qx_ff[15], qx_ff}; end
         4'd6:    begin mul_a = {qy_ff[15], qy_ff}; mul_b = {qy_ff[15], qy_ff}; end
         4'd7:    begin mul_a = {qz_ff[15], qz_ff}; mul_b = {qz_ff[15], qz_ff}; end
         4'd8:    begin mul_a = {3'b0, s_hi}; mul_b = {3'b0, s_hi}; end
         4'd9:    begin mul_a = {3'b0, s_hi}; mul_b = {3'b0, s_lo}; end
         4'd10:   begin mul_a = {3'b0, s_lo}; mul_b = {3'b0, s_lo}; end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   assign prod     = mul_a * mul_b;
   assign prod_ext = SQ_W'($unsigned(prod));

   // The CORDIC serves the roll asin first, then the pitch atan2.
   assign cor_y = (state_ff == ST_ROOT) ? {acca_ff, 1'b0} : {accb_ff, 1'b0};
   assign cor_x = (state_ff == ST_ROOT) ? CIN_W'($signed({1'b0, isq_root}))
                                        : {accc_ff[PRD_W-1], accc_ff};

   // Roll sum is averaged first, then pitch sum.
   assign div_sum   = (state_ff == ST_AVG_GO) ? rsum_ff : psum_ff;
   assign div_mag   = div_sum[SUM_W-1] ? SUM_W'(-div_sum) : SUM_W'(div_sum);
   assign div_numer = DN_W'({div_mag, 1'b0}) + DN_W'(CAL_SAMPLES);
   assign avg_q     = div_quot[OFF_W-1:0];
   assign pang      = -cor_ang;
   assign count_nx  = {1'b0, count_ff} + 13'd1;
   assign rbase     = (count_ff == '0) ? '0 : rsum_ff;
   assign pbase     = (count_ff == '0) ? '0 : psum_ff;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cal_in       = cal_ff;
      count_in     = count_ff;
      rsum_in      = rsum_ff;
      psum_in      = psum_ff;
      roff_in      = roff_ff;
      poff_in      = poff_ff;
      qw_in        = qw_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      qz_in        = qz_ff;
      acca_in      = acca_ff;
      accb_in      = accb_ff;
      accc_in      = accc_ff;
      sq_in        = sq_ff;
      rang_in      = rang_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      isq_start    = 1'b0;
      cor_start    = 1'b0;
      div_start    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               case (op)
                  OP_SAMPLE: begin
                     if (!cal_ff) begin
                        qw_in    = req_tdata[15:0];
                        qx_in    = req_tdata[31:16];
                        qy_in    = req_tdata[47:32];
                        qz_in    = req_tdata[63:48];
                        acca_in  = '0;
                        accb_in  = '0;
                        accc_in  = '0;
                        step_in  = '0;
                        state_in = ST_MAC;
                     end
                  end
                  OP_CMD: begin
                     if (cal_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = {scale_sat(req_tdata[95:80], poff_ff),
                                        scale_sat(req_tdata[79:64], roff_ff)};
                     end
                  end
                  OP_RECAL: cal_in = 1'b0;
                  default: ;
               endcase
            end
         end
         ST_MAC: begin
            step_in = step_ff + 4'd1;
            case (step_ff)
               4'd0, 4'd1: acca_in = acca_ff + prod;
               4'd2:       accb_in = accb_ff + prod;
               4'd3:       accb_in = accb_ff - prod;
               4'd4, 4'd5: accc_in = accc_ff + prod;
               4'd6, 4'd7: accc_in = accc_ff - prod;
               4'd8: begin
                  if (a_sat) begin
                     // asin saturates at a quarter turn; roll is its negation.
                     rang_in   = acca_ff[PRD_W-1] ? HALF_PI_Q13 : -HALF_PI_Q13;
                     cor_start = 1'b1;
                     state_in  = ST_PITCH;
                  end else begin
                     sq_in = prod_ext << 28;
                  end
               end
               4'd9:  sq_in = sq_ff + (prod_ext << 15);
               4'd10: sq_in = sq_ff + prod_ext;
               default: begin
                  isq_start = 1'b1;
                  state_in  = ST_ROOT;
               end
            endcase
         end
         ST_ROOT: begin
            if (isq_done) begin
               cor_start = 1'b1;
               state_in  = ST_ROLL;
            end
         end
         ST_ROLL: begin
            if (cor_done) begin
               rang_in   = -cor_ang;
               cor_start = 1'b1;
               state_in  = ST_PITCH;
            end
         end
         ST_PITCH: begin
            if (cor_done) begin
               // Crosswise sums: pitch feeds the roll sum and vice versa.
               rsum_in = rbase + SUM_W'(pang);
               psum_in = pbase + SUM_W'(rang_ff);
               if (count_nx >= 13'(CAL_SAMPLES)) begin
                  count_in = '0;
                  state_in = ST_AVG_GO;
               end else begin
                  count_in = count_nx[11:0];
                  state_in = ST_IDLE;
               end
            end
         end
         ST_AVG_GO: begin
            div_start = 1'b1;
            state_in  = ST_AVG_R;
         end
         ST_AVG_R: begin
            if (div_done) begin
               roff_in   = rsum_ff[SUM_W-1] ? -avg_q : avg_q;
               div_start = 1'b1;
               state_in  = ST_AVG_P;
            end
         end
         ST_AVG_P: begin
            if (div_done) begin
               poff_in  = psum_ff[SUM_W-1] ? -avg_q : avg_q;
               cal_in   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cal_ff       <= 1'b1;
         count_ff     <= '0;
         rsum_ff      <= '0;
         psum_ff      <= '0;
         roff_ff      <= '0;
         poff_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cal_ff       <= cal_in;
         count_ff     <= count_in;
         rsum_ff      <= rsum_in;
         psum_ff      <= psum_in;
         roff_ff      <= roff_in;
         poff_ff      <= poff_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_ff     <= step_in;
      qw_ff       <= qw_in;
      qx_ff       <= qx_in;
      qy_ff       <= qy_in;
      qz_ff       <= qz_in;
      acca_ff     <= acca_in;
      accb_ff     <= accb_in;
      accc_ff     <= accc_in;
      sq_ff       <= sq_in;
      rang_ff     <= rang_in;
      rsp_data_ff <= rsp_data_in;
   end

   abl_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (isq_start),
      .radicand (RAD_W'((SQ_W'(1) << 56) - sq_ff)),
      .done     (isq_done),
      .root     (isq_root)
   );

   abl_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cor_start),
      .y_val (cor_y),
      .x_val (cor_x),
      .done  (cor_done),
      .angle (cor_ang)
   );

   abl_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (DD_W'(2 * CAL_SAMPLES)),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTH
   // A new response only follows an accepted command.
   a_rsp_from_cmd: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_xfer && op == OP_CMD))
      else $error("response without a command");

   // No transfer is taken while a sample is in work.
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_tready)
      else $error("input taken while busy");

   // Sample processing only happens during calibration.
   a_mac_uncal: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAC) |-> !cal_ff)
      else $error("sample processed while calibrated");

   // The sample count never reaches the calibration length.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, count_ff} < 13'(CAL_SAMPLES))
      else $error("sample count out of range");
`endif

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

// Stream-level testbench for attitude_bias_leveler.
// An initial block queues events (samples, commands, recalibrate requests and
// noise). A clocked driver presents them on the req_ stream. At every accepted
// transfer the driver runs the leveler predictor on that event and queues any
// expected response. A clocked monitor compares each rsp_ transfer with the
// oldest expectation, field by field.
module tb_top
   import abl_pkg::*;
();

   // Opcode 3 has no meaning; the block must ignore it.
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int N_CAL = 200;
   localparam longint PI_Q20_L = 3294199;
   localparam int HALF_PI = 12868;
   localparam longint CYCLE_LIMIT = 2000000;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = 200;

   typedef struct {
      logic [1:0] op;
      shortint    w, x, y, z;
      shortint    roll, pitch;
   } event_type;

   typedef struct {
      shortint roll, pitch;
   } level_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // quat_w, quat_x, quat_y, quat_z, cmd_roll, cmd_pitch, 16 bits each
   logic [95:0] req_tdata = '0;
   // opcode
   logic [1:0]  req_tuser = 2'd0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // out_roll, out_pitch, 16 bits each
   logic [31:0] rsp_tdata;

   event_type event_q[$];
   level_type level_q[$];
   event_type cur_event;

   // Predictor state.
   bit      is_calibrated = 1'b1;
   int      cal_count = 0;
   longint  roll_acc = 0, pitch_acc = 0;
   longint  roll_bias = 0, pitch_bias = 0;

   int      send_gap_pct = 0;
   int      recv_gap_pct = 0;
   int      holds_asked = 0;
   int      holds_done = 0;
   int      hold_left = 0;
   int      errors = 0;
   int      n_events = 0, n_levels = 0, n_samples = 0, n_cals = 0;
   longint  cycles = 0;

   attitude_bias_leveler u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   // Vectoring CORDIC arctangent, Q13 result from Q20 accumulation.
   function automatic int cordic_angle(longint y, longint x);
      longint tab[9] = '{823550, 486170, 256879, 130396, 65451, 32757,
                         16383, 8192, 4096};
      longint z, xs, ys, step;
      z = 0;
      if (x == 0 && y == 0) return 0;
      x = x * 256;
      y = y * 256;
      if (x < 0) begin
         z = (y >= 0) ? PI_Q20_L : -PI_Q20_L;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < 21; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         step = (i < 9) ? tab[i] : (64'sd1 <<< (20 - i));
         if (y > 0) begin
            x = x + ys;
            y = y - xs;
            z = z + step;
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - step;
         end
      end
      return int'((z + 64) >>> 7);
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // Arcsine of a Q28 sine, saturated at a quarter turn.
   function automatic int arcsine_q13(longint s);
      longint unsigned c2;
      if (s >= (64'sd1 <<< 28)) return HALF_PI;
      if (s <= -(64'sd1 <<< 28)) return -HALF_PI;
      c2 = (64'd1 << 56) - longint'(s * s);
      return cordic_angle(s, longint'(floor_sqrt(c2)));
   endfunction

   function automatic longint mean_rounded(longint sum);
      longint mag, q;
      mag = (sum < 0) ? -sum : sum;
      q = (2 * mag + N_CAL) / (2 * N_CAL);
      return (sum < 0) ? -q : q;
   endfunction

   function automatic shortint scale_level(shortint cmd, longint bias);
      longint v;
      v = (3 * longint'(cmd) + 2 * bias + 1) >>> 1;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return shortint'(v);
   endfunction

   // Updates the predictor for one accepted event and queues its response.
   task automatic level_event(event_type e);
      longint w, x, y, z;
      longint roll_ang, pitch_ang;
      level_type r;
      w = e.w; x = e.x; y = e.y; z = e.z;
      n_events++;
      case (e.op)
         OP_SAMPLE: begin
            if (!is_calibrated) begin
               n_samples++;
               roll_ang = -arcsine_q13(2 * (x * y + w * z));
               pitch_ang = -cordic_angle(2 * (w * y - x * z),
                                         w * w + x * x - y * y - z * z);
               if (cal_count == 0) begin
                  roll_acc = 0;
                  pitch_acc = 0;
               end
               // Angles cross over: pitch feeds the roll bias and vice versa.
               roll_acc += pitch_ang;
               pitch_acc += roll_ang;
               cal_count = (cal_count + 1) & 12'hFFF;
               if (cal_count >= N_CAL) begin
                  roll_bias = mean_rounded(roll_acc);
                  pitch_bias = mean_rounded(pitch_acc);
                  cal_count = 0;
                  is_calibrated = 1'b1;
                  n_cals++;
               end
            end
         end
         OP_CMD: begin
            if (is_calibrated) begin
               r.roll = scale_level(e.roll, roll_bias);
               r.pitch = scale_level(e.pitch, pitch_bias);
               level_q.push_back(r);
            end
         end
         OP_RECAL: is_calibrated = 1'b0;
         default: ;
      endcase
   endtask

   // Driver: presents queued events and predicts each one at its transfer.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tuser <= 2'd0;
      end else begin
         if (req_tvalid && req_tready) level_event(cur_event);
         if (!req_tvalid || req_tready) begin
            if (event_q.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
               cur_event = event_q.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= cur_event.op;
               req_tdata <= {cur_event.pitch, cur_event.roll, cur_event.z,
                             cur_event.y, cur_event.x, cur_event.w};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls, plus long hold-offs on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_done < holds_asked) begin
         rsp_tready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         holds_done <= holds_done + 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_gap_pct);
      end
   end

   // Monitor: checks every response transfer against the oldest expectation.
   always @(posedge clock) begin
      level_type exp_lvl;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (level_q.size() == 0) begin
            $error("unexpected response roll=%0d pitch=%0d",
                   $signed(rsp_tdata[15:0]), $signed(rsp_tdata[31:16]));
            errors++;
         end else begin
            exp_lvl = level_q.pop_front();
            n_levels++;
            if (rsp_tdata[15:0] !== exp_lvl.roll) begin
               $error("out_roll expected %0d got %0d", exp_lvl.roll,
                      $signed(rsp_tdata[15:0]));
               errors++;
            end
            if (rsp_tdata[31:16] !== exp_lvl.pitch) begin
               $error("out_pitch expected %0d got %0d", exp_lvl.pitch,
                      $signed(rsp_tdata[31:16]));
               errors++;
            end
         end
      end
   end

   // Watchdog on total run length.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout with %0d responses outstanding", level_q.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic event_type make_event(logic [1:0] op, shortint w, shortint x,
                                            shortint y, shortint z, shortint roll,
                                            shortint pitch);
      event_type e;
      e.op = op; e.w = w; e.x = x; e.y = y; e.z = z;
      e.roll = roll; e.pitch = pitch;
      return e;
   endfunction

   function automatic shortint rnd16();
      return shortint'($urandom_range(16'hFFFF));
   endfunction

   function automatic shortint edge16();
      shortint vals[6] = '{16'sh7FFF, -16'sh8000, 16'sh4000, -16'sh4000, 0, -1};
      return vals[$urandom_range(5)];
   endfunction

   // Sample around a common tilt so calibrations end with real offsets.
   function automatic event_type tilt_sample(int bx, int by, int bz);
      int kind;
      kind = $urandom_range(9);
      if (kind == 0)
         return make_event(OP_SAMPLE, rnd16(), rnd16(), rnd16(), rnd16(),
                           rnd16(), rnd16());
      if (kind == 1)
         return make_event(OP_SAMPLE, edge16(), edge16(), edge16(), edge16(),
                           rnd16(), rnd16());
      return make_event(OP_SAMPLE, shortint'(15000 + $urandom_range(1384)),
                        shortint'(bx + int'($urandom_range(800)) - 400),
                        shortint'(by + int'($urandom_range(800)) - 400),
                        shortint'(bz + int'($urandom_range(800)) - 400),
                        rnd16(), rnd16());
   endfunction

   function automatic event_type rnd_cmd();
      if ($urandom_range(9) == 0)
         return make_event(OP_CMD, rnd16(), rnd16(), rnd16(), rnd16(),
                           edge16(), edge16());
      return make_event(OP_CMD, rnd16(), rnd16(), rnd16(), rnd16(),
                        rnd16(), rnd16());
   endfunction

   // Waits until every queued event has gone and every response has come,
   // then lets a sample in flight finish.
   task automatic drain();
      while (event_q.size() > 0 || req_tvalid || level_q.size() > 0 ||
             hold_left > 0 || holds_done < holds_asked)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int bx, by, bz;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part: zero offsets after reset, extreme commands, ignored
      // events, repeated recalibrate, commands while calibrating, and
      // degenerate and extreme quaternions.
      event_q.push_back(make_event(OP_CMD, 0, 0, 0, 0, 16'sh7FFF, -16'sh8000));
      event_q.push_back(make_event(OP_CMD, -1, -1, -1, -1, -16'sh8000, 16'sh7FFF));
      event_q.push_back(make_event(OP_CMD, 0, 0, 0, 0, 0, 0));
      event_q.push_back(make_event(OP_CMD, 0, 0, 0, 0, 1, -1));
      event_q.push_back(make_event(OP_SAMPLE, 16384, 100, 200, 300, 0, 0));
      event_q.push_back(make_event(OP_UNUSED, -1, -1, -1, -1, -1, -1));
      event_q.push_back(make_event(OP_RECAL, 0, 0, 0, 0, 0, 0));
      event_q.push_back(make_event(OP_RECAL, -1, -1, -1, -1, -1, -1));
      event_q.push_back(make_event(OP_CMD, 0, 0, 0, 0, 100, 100));
      event_q.push_back(make_event(OP_SAMPLE, 0, 0, 0, 0, 0, 0));
      event_q.push_back(make_event(OP_SAMPLE, 16384, 0, 0, 0, 0, 0));
      event_q.push_back(make_event(OP_SAMPLE, -16384, 0, 0, 0, 0, 0));
      event_q.push_back(make_event(OP_SAMPLE, 11585, 11585, 11585, 11585, 0, 0));
      event_q.push_back(make_event(OP_SAMPLE, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                                   16'sh7FFF, 0, 0));
      event_q.push_back(make_event(OP_SAMPLE, -16'sh8000, -16'sh8000, -16'sh8000,
                                   -16'sh8000, 0, 0));
      event_q.push_back(make_event(OP_SAMPLE, 0, 16384, 0, 0, 0, 0));
      event_q.push_back(make_event(OP_SAMPLE, 0, 0, -16384, 0, 0, 0));
      event_q.push_back(make_event(OP_SAMPLE, 0, 0, 0, 16384, 0, 0));
      event_q.push_back(make_event(OP_UNUSED, 0, 0, 0, 0, 0, 0));
      drain();

      // Finish the open calibration, then back up the response path with a
      // long hold-off while commands keep coming.
      for (int i = 0; i < N_CAL; i++) event_q.push_back(tilt_sample(0, 0, 0));
      drain();
      holds_asked = holds_asked + 1;
      for (int i = 0; i < 40; i++) event_q.push_back(rnd_cmd());
      drain();

      // Random part in three idle regimes, each with calibrations around a
      // fresh tilt and stretches of commands.
      for (int mode = 0; mode < 3; mode++) begin
         send_gap_pct = (mode == 0) ? 24 : (mode == 1) ? 62 : 0;
         recv_gap_pct = (mode == 0) ? 62 : (mode == 1) ? 24 : 0;
         for (int blk = 0; blk < 2; blk++) begin
            bx = int'($urandom_range(8000)) - 4000;
            by = int'($urandom_range(8000)) - 4000;
            bz = int'($urandom_range(4000)) - 2000;
            event_q.push_back(make_event(OP_RECAL, rnd16(), rnd16(), rnd16(),
                                         rnd16(), rnd16(), rnd16()));
            for (int i = 0; i < N_CAL + 20; i++) begin
               case ($urandom_range(19))
                  0, 1: event_q.push_back(rnd_cmd());
                  2: event_q.push_back(make_event(OP_UNUSED, rnd16(), rnd16(),
                        rnd16(), rnd16(), rnd16(), rnd16()));
                  3: event_q.push_back(make_event(OP_RECAL, rnd16(), rnd16(),
                        rnd16(), rnd16(), rnd16(), rnd16()));
                  default: event_q.push_back(tilt_sample(bx, by, bz));
               endcase
            end
            for (int i = 0; i < 60; i++) begin
               if ($urandom_range(9) == 0)
                  event_q.push_back(tilt_sample(bx, by, bz));
               else
                  event_q.push_back(rnd_cmd());
            end
            drain();
         end
      end

      $display("Run covered %0d transfers: %0d samples taken, %0d calibrations,",
               n_events, n_samples, n_cals);
      $display("and %0d leveled command responses checked.", n_levels);
      if (errors == 0 && level_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
